// ----- rtl/core/pds_pkg.sv -----
// ----------------------------------------------------------------------------
// pds_pkg
// Shared widths, constants and payload types for the PLL divider search.
// ----------------------------------------------------------------------------
package pds_pkg;

  // Parameter defaults
  localparam int MAX_REF_DIV_DEF  = 2;
  localparam int MAX_POST_DIV_DEF = 7;

  // Field widths
  localparam int FREQ_W = 22;
  localparam int FB_W   = 9;
  localparam int REF_W  = 4;   // holds the largest reference divider
  localparam int PD_W   = 3;
  localparam int D_W    = 10;  // ref * pd1 * pd2 up to 15 * 7 * 7
  localparam int NUM_W  = 12;  // rounding error never exceeds half of 6400
  localparam int WORD_W = 27;
  localparam int TD_W   = FREQ_W + D_W;

  // Feedback divider arithmetic: fb = floor((T*D + 3200) / 6400)
  localparam int SCALE  = 6400;
  localparam int RND    = 3200;
  localparam int FRAC_W = 8;           // 6400 = 25 << 8
  localparam int Q_W    = TD_W + 1 - FRAC_W;
  localparam int QMIN   = 25 * 16;     // fb >= 16
  localparam int QLIM   = 25 * 512;    // fb <= 511
  localparam int QLO_W  = 14;          // width of q below QLIM
  localparam int RECIP  = 5243;        // ceil(2^17 / 25), exact for q < QLIM
  localparam int RSH    = 17;
  localparam int PROD_W = QLO_W + 13;

  // Best candidate so far
  typedef struct packed {
    logic               have;
    logic [NUM_W-1:0]   num;
    logic [D_W-1:0]     den;
    logic [FB_W-1:0]    fb;
    logic [REF_W-1:0]   rdiv;
    logic [PD_W-1:0]    pd1;
    logic [PD_W-1:0]    pd2;
    logic [FREQ_W-1:0]  ach_num;   // 6400 * fb, divided by den at the end
  } pds_best_t;

  // Item moving along the search chain
  typedef struct packed {
    logic              valid;
    logic [FREQ_W-1:0] target;
    pds_best_t         best;
  } pds_stage_t;

  // Item moving along the divider chain
  typedef struct packed {
    logic              valid;
    pds_best_t         best;
    logic [D_W-1:0]    rem;
    logic [FREQ_W-1:0] quo;
  } pds_div_t;

endpackage

// ----- rtl/core/pds_search_cell.sv -----
// ----------------------------------------------------------------------------
// pds_search_cell
// Evaluates one divider combination and keeps the better of it and the best
// so far. Four pipeline stages; a new item may enter every cycle.
// ----------------------------------------------------------------------------
module pds_search_cell #(
  parameter int REF = 1,
  parameter int PD1 = 1,
  parameter int PD2 = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pds_pkg::pds_stage_t in_s,
  output pds_pkg::pds_stage_t out_s
);

  localparam logic [pds_pkg::D_W-1:0] D_C = pds_pkg::D_W'(REF * PD1 * PD2);

  // Stage 1: T * D
  logic                          v1_r;
  pds_pkg::pds_best_t            b1_r;
  logic [pds_pkg::TD_W-1:0]      td1_r;
  // Stage 2: rounded quotient by 256, reciprocal product
  logic                          v2_r;
  pds_pkg::pds_best_t            b2_r;
  logic [pds_pkg::FREQ_W-1:0]    td2_r;
  logic                          inr2_r;
  logic [pds_pkg::PROD_W-1:0]    prod2_r;
  // Stage 3: feedback divider and error
  logic                          v3_r;
  pds_pkg::pds_best_t            b3_r;
  logic                          inr3_r;
  logic [pds_pkg::FB_W-1:0]      fb3_r;
  logic [pds_pkg::FREQ_W-1:0]    a3_r;
  logic [pds_pkg::NUM_W-1:0]     num3_r;
  // Stage 4: compare and pick
  pds_pkg::pds_stage_t           out_r;
  logic [pds_pkg::FREQ_W-1:0]    t1_r, t2_r, t3_r;

  logic [pds_pkg::TD_W:0]        sum2;
  logic [pds_pkg::Q_W-1:0]       q2;
  logic [pds_pkg::FB_W-1:0]      fb3_nxt;
  logic [pds_pkg::FREQ_W-1:0]    a3_nxt;
  logic [pds_pkg::FREQ_W-1:0]    diff3;
  logic [pds_pkg::FREQ_W-1:0]    lhs4, rhs4;
  logic                          take4;
  pds_pkg::pds_best_t            b4_nxt;

  // Round and range-check the feedback divider
  always_comb begin
    sum2 = {1'b0, td1_r} + (pds_pkg::TD_W + 1)'(pds_pkg::RND);
    q2   = sum2[pds_pkg::TD_W:pds_pkg::FRAC_W];
  end

  // Divide by 25 and form the error against the target
  always_comb begin
    fb3_nxt = prod2_r[pds_pkg::RSH+pds_pkg::FB_W-1:pds_pkg::RSH];
    a3_nxt  = pds_pkg::FREQ_W'(fb3_nxt) * pds_pkg::FREQ_W'(pds_pkg::SCALE);
    if (a3_nxt >= td2_r) begin
      diff3 = a3_nxt - td2_r;
    end else begin
      diff3 = td2_r - a3_nxt;
    end
  end

  // Cross-multiply errors; strict less keeps the earlier candidate on ties
  always_comb begin
    lhs4  = pds_pkg::FREQ_W'(num3_r) * pds_pkg::FREQ_W'(b3_r.den);
    rhs4  = pds_pkg::FREQ_W'(b3_r.num) * pds_pkg::FREQ_W'(D_C);
    take4 = inr3_r && (!b3_r.have || (lhs4 < rhs4));
    b4_nxt = b3_r;
    if (take4) begin
      b4_nxt.have    = 1'b1;
      b4_nxt.num     = num3_r;
      b4_nxt.den     = D_C;
      b4_nxt.fb      = fb3_r;
      b4_nxt.rdiv    = pds_pkg::REF_W'(REF);
      b4_nxt.pd1     = pds_pkg::PD_W'(PD1);
      b4_nxt.pd2     = pds_pkg::PD_W'(PD2);
      b4_nxt.ach_num = a3_r;
    end
  end

  // Advance valid bits and payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_r.valid <= 1'b0;
    end else begin
      v1_r        <= in_s.valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_r.valid <= v3_r;
    end
    t1_r    <= in_s.target;
    b1_r    <= in_s.best;
    td1_r   <= pds_pkg::TD_W'(in_s.target) * pds_pkg::TD_W'(D_C);
    t2_r    <= t1_r;
    b2_r    <= b1_r;
    td2_r   <= td1_r[pds_pkg::FREQ_W-1:0];
    inr2_r  <= (q2 >= pds_pkg::Q_W'(pds_pkg::QMIN)) && (q2 < pds_pkg::Q_W'(pds_pkg::QLIM));
    prod2_r <= pds_pkg::PROD_W'(q2[pds_pkg::QLO_W-1:0]) * pds_pkg::PROD_W'(pds_pkg::RECIP);
    t3_r    <= t2_r;
    b3_r    <= b2_r;
    inr3_r  <= inr2_r;
    fb3_r   <= fb3_nxt;
    a3_r    <= a3_nxt;
    num3_r  <= diff3[pds_pkg::NUM_W-1:0];
    out_r.target <= t3_r;
    out_r.best   <= b4_nxt;
  end

  assign out_s = out_r;

endmodule

// ----- rtl/core/pds_div_cell.sv -----
// ----------------------------------------------------------------------------
// pds_div_cell
// One restoring-division step: produces one quotient bit of the achieved
// frequency per cell, registered.
// ----------------------------------------------------------------------------
module pds_div_cell #(
  parameter int BIT = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pds_pkg::pds_div_t in_s,
  output pds_pkg::pds_div_t out_s
);

  logic [pds_pkg::D_W:0] trial;
  logic                  ge;
  pds_pkg::pds_div_t     out_r;
  pds_pkg::pds_div_t     nxt;

  // Shift in the next dividend bit and subtract when it fits
  always_comb begin
    trial = {in_s.rem, in_s.best.ach_num[BIT]};
    ge    = trial >= {1'b0, in_s.best.den};
    nxt   = in_s;
    if (ge) begin
      nxt.rem = pds_pkg::D_W'(trial - {1'b0, in_s.best.den});
    end else begin
      nxt.rem = trial[pds_pkg::D_W-1:0];
    end
    nxt.quo[BIT] = ge;
  end

  // Advance valid bit and payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end else begin
      out_r.valid <= in_s.valid;
    end
    out_r.best <= nxt.best;
    out_r.rem  <= nxt.rem;
    out_r.quo  <= nxt.quo;
  end

  assign out_s = out_r;

endmodule

// ----- rtl/core/pll_divider_search.sv -----
// ----------------------------------------------------------------------------
// pll_divider_search
// Finds PLL divider settings whose output frequency is closest to a target.
// ----------------------------------------------------------------------------
// Pipeline: one search cell per divider combination (56 at default) followed
//   by 22 divider steps between accept and out_valid.
// Throughput: one item per cycle; busy is always low, set by the pipelined
//   chain of search cells followed by the divider chain.
// Reset: synchronous active-low rst_n clears all valid bits; results cannot
//   be stalled and appear for exactly one cycle.
module pll_divider_search #(
  parameter int MAX_REF_DIV  = pds_pkg::MAX_REF_DIV_DEF,
  parameter int MAX_POST_DIV = pds_pkg::MAX_POST_DIV_DEF,
  parameter int REF_PW       = $clog2(MAX_REF_DIV + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [pds_pkg::FREQ_W-1:0]  in_target_freq,
  output logic                        out_valid,
  output logic                        out_found,
  output logic [pds_pkg::FB_W-1:0]    out_feedback_div,
  output logic [REF_PW-1:0]           out_reference_div,
  output logic [pds_pkg::PD_W-1:0]    out_post_div_one,
  output logic [pds_pkg::PD_W-1:0]    out_post_div_two,
  output logic [pds_pkg::FREQ_W-1:0]  out_achieved_freq,
  output logic [pds_pkg::WORD_W-1:0]  out_pll_word
);

  localparam int NPD   = MAX_POST_DIV * (MAX_POST_DIV + 1) / 2;
  localparam int NCELL = MAX_REF_DIV * NPD;

  pds_pkg::pds_stage_t chain [NCELL+1];
  pds_pkg::pds_div_t   dchain [pds_pkg::FREQ_W+1];
  pds_pkg::pds_best_t  fin;

  assign busy = 1'b0;

  // Feed the chain with an empty best candidate
  always_comb begin
    chain[0].valid        = start && !busy;
    chain[0].target       = in_target_freq;
    chain[0].best         = '0;
    chain[0].best.den     = pds_pkg::D_W'(1);
  end

  // One search cell per combination, in scan order
  for (genvar r = 1; r <= MAX_REF_DIV; r++) begin : g_ref
    for (genvar p1 = 1; p1 <= MAX_POST_DIV; p1++) begin : g_pd1
      for (genvar p2 = 1; p2 <= p1; p2++) begin : g_pd2
        localparam int IDX = (r - 1) * NPD + (p1 * (p1 - 1)) / 2 + p2 - 1;
        pds_search_cell #(
          .REF (r),
          .PD1 (p1),
          .PD2 (p2)
        ) u_cell (
          .clk   (clk),
          .rst_n (rst_n),
          .in_s  (chain[IDX]),
          .out_s (chain[IDX+1])
        );
      end
    end
  end

  // Divide 6400 * fb by the combined divider, one bit per cell
  always_comb begin
    dchain[0].valid = chain[NCELL].valid;
    dchain[0].best  = chain[NCELL].best;
    dchain[0].rem   = '0;
    dchain[0].quo   = '0;
  end

  for (genvar k = 0; k < pds_pkg::FREQ_W; k++) begin : g_div
    pds_div_cell #(
      .BIT (pds_pkg::FREQ_W - 1 - k)
    ) u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .in_s  (dchain[k]),
      .out_s (dchain[k+1])
    );
  end

  // Drive results; zero everything when no combination fit
  assign fin       = dchain[pds_pkg::FREQ_W].best;
  assign out_valid = dchain[pds_pkg::FREQ_W].valid;

  always_comb begin
    out_found         = fin.have;
    out_feedback_div  = '0;
    out_reference_div = '0;
    out_post_div_one  = '0;
    out_post_div_two  = '0;
    out_achieved_freq = '0;
    out_pll_word      = '0;
    if (fin.have) begin
      out_feedback_div  = fin.fb;
      out_reference_div = fin.rdiv[REF_PW-1:0];
      out_post_div_one  = fin.pd1;
      out_post_div_two  = fin.pd2;
      out_achieved_freq = dchain[pds_pkg::FREQ_W].quo;
      out_pll_word      = {fin.pd2, 5'b0, fin.pd1, fin.rdiv, 3'b0, fin.fb};
    end
  end

endmodule

// ----- sim/tb_pll_divider_search.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pll_divider_search
// Drives target frequencies into the divider search, from a directed table
// and then at random, predicts the chosen dividers by an exhaustive scan and
// compares every result field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_pll_divider_search;

  localparam int N_RANDOM   = 550;
  localparam int WDOG_LIMIT = 20000;
  localparam int DRAIN_CYC  = 300;

  typedef struct packed {
    logic                       found;
    logic [pds_pkg::FB_W-1:0]   fb;
    logic [1:0]                 rdiv;
    logic [pds_pkg::PD_W-1:0]   pd1;
    logic [pds_pkg::PD_W-1:0]   pd2;
    logic [pds_pkg::FREQ_W-1:0] ach;
    logic [pds_pkg::WORD_W-1:0] word;
  } divider_set_t;

  typedef struct {
    logic [pds_pkg::FREQ_W-1:0] target;
    logic                       typed;
    divider_set_t               want;
  } dir_row_t;

  logic                         clk;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  logic [pds_pkg::FREQ_W-1:0]   in_target_freq;
  logic                         out_valid;
  logic                         out_found;
  logic [pds_pkg::FB_W-1:0]     out_feedback_div;
  logic [1:0]                   out_reference_div;
  logic [pds_pkg::PD_W-1:0]     out_post_div_one;
  logic [pds_pkg::PD_W-1:0]     out_post_div_two;
  logic [pds_pkg::FREQ_W-1:0]   out_achieved_freq;
  logic [pds_pkg::WORD_W-1:0]   out_pll_word;

  divider_set_t pending_sets[$];
  int           n_errors;
  int           idle_cycles;

  pll_divider_search dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_target_freq(in_target_freq), .out_valid(out_valid),
    .out_found(out_found), .out_feedback_div(out_feedback_div),
    .out_reference_div(out_reference_div), .out_post_div_one(out_post_div_one),
    .out_post_div_two(out_post_div_two), .out_achieved_freq(out_achieved_freq),
    .out_pll_word(out_pll_word)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Scan every divider combination; keep the first with the smallest error
  function automatic divider_set_t best_dividers(logic [pds_pkg::FREQ_W-1:0] t);
    divider_set_t res;
    logic [63:0]  d, td, fb, a, num, bnum, bden;
    logic         have;
    res  = '0;
    have = 1'b0;
    bnum = 0;
    bden = 1;
    for (int r = 1; r <= pds_pkg::MAX_REF_DIV_DEF; r++)
      for (int p1 = 1; p1 <= pds_pkg::MAX_POST_DIV_DEF; p1++)
        for (int p2 = 1; p2 <= p1; p2++) begin
          d  = 64'(r * p1 * p2);
          td = 64'(t) * d;
          fb = (2 * td + 64'(pds_pkg::SCALE)) / (2 * 64'(pds_pkg::SCALE));
          if (fb >= 16 && fb <= 511) begin
            a   = 64'(pds_pkg::SCALE) * fb;
            num = (a > td) ? a - td : td - a;
            if (!have || num * bden < bnum * d) begin
              have      = 1'b1;
              bnum      = num;
              bden      = d;
              res.found = 1'b1;
              res.fb    = fb[pds_pkg::FB_W-1:0];
              res.rdiv  = r[1:0];
              res.pd1   = p1[pds_pkg::PD_W-1:0];
              res.pd2   = p2[pds_pkg::PD_W-1:0];
              res.ach   = pds_pkg::FREQ_W'(a / d);
              res.word  = pds_pkg::WORD_W'((64'(p2) << 24) | (64'(p1) << 16) |
                                           (64'(r) << 12) | fb);
            end
          end
        end
    return res;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d", field, got, want);
    n_errors++;
  endtask

  // Hold start for one item until accepted
  task automatic send_target(logic [pds_pkg::FREQ_W-1:0] t, divider_set_t want);
    in_target_freq <= t;
    start          <= 1'b1;
    do @(posedge clk); while (busy);
    pending_sets.push_back(want);
    @(negedge clk);
  endtask

  task automatic random_gap();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    divider_set_t w;
    if (rst_n && out_valid) begin
      if (pending_sets.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        w = pending_sets.pop_front();
        if (out_found !== w.found) report_mismatch("found", out_found, w.found);
        if (out_feedback_div !== w.fb) report_mismatch("fb", out_feedback_div, w.fb);
        if (out_reference_div !== w.rdiv)
          report_mismatch("ref", out_reference_div, w.rdiv);
        if (out_post_div_one !== w.pd1) report_mismatch("pd1", out_post_div_one, w.pd1);
        if (out_post_div_two !== w.pd2) report_mismatch("pd2", out_post_div_two, w.pd2);
        if (out_achieved_freq !== w.ach)
          report_mismatch("achieved", out_achieved_freq, w.ach);
        if (out_pll_word !== w.word) report_mismatch("word", out_pll_word, w.word);
      end
    end
  end

  // Watchdog: count cycles where nothing is accepted on either side
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    dir_row_t                   rows[$];
    dir_row_t                   row;
    divider_set_t               zero_set;
    logic [pds_pkg::FREQ_W-1:0] t;
    n_errors       = 0;
    idle_cycles    = 0;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_target_freq = '0;
    zero_set       = '0;

    // Directed table: zero and unreachable targets type their result in
    row.typed = 1'b1; row.want = zero_set;
    row.target = 22'd0;       rows.push_back(row);
    row.target = 22'h3FFFFF;  rows.push_back(row);
    row.target = 22'd1;       rows.push_back(row);
    row.target = 22'd3270400 + 22'd6400; rows.push_back(row);
    row.typed = 1'b0;
    // Bounds of the feedback range, half-up ties, single bits, typical clocks
    begin
      logic [pds_pkg::FREQ_W-1:0] dl[$] = '{22'd256*22'd400/22'd49,
        22'd256*22'd400/22'd98,
        22'd3270400, 22'd3270399, 22'd102400, 22'd153600, 22'd3200, 22'd1600,
        22'd256*22'd485, 22'd256*22'd525, 22'd256*22'd600, 22'd256*22'd100,
        22'h2AAAAA, 22'h155555, 22'd12800, 22'd9600, 22'd819200, 22'd1234567};
      foreach (dl[i]) begin
        row.target = dl[i];
        rows.push_back(row);
      end
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (rows[i]) begin
      send_target(rows[i].target,
                  rows[i].typed ? rows[i].want : best_dividers(rows[i].target));
      random_gap();
    end
    start <= 1'b0;

    // Random part: mostly reachable targets, some anywhere in the field
    for (int i = 0; i < N_RANDOM; i++) begin
      case ($urandom_range(0, 9))
        0: t = pds_pkg::FREQ_W'($urandom_range(0, 22'h3FFFFF));
        1: t = pds_pkg::FREQ_W'($urandom_range(0, 4095));
        default: t = pds_pkg::FREQ_W'($urandom_range(400, 3300000));
      endcase
      send_target(t, best_dividers(t));
      random_gap();
      // Let the pipeline drain once midway
      if (i == N_RANDOM / 2) begin
        start <= 1'b0;
        while (pending_sets.size() != 0) @(negedge clk);
      end
    end
    start <= 1'b0;

    while (pending_sets.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
    if (n_errors == 0 && pending_sets.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
